FILE: design/groa_pkg.sv
// ----------------------------------------------------------------------------
// groa_pkg
// shared widths, operation codes and map port types for the rectangle
// occupancy allocator
// ----------------------------------------------------------------------------
package groa_pkg;

	// request and response field widths
	localparam int FUNC_W  = 3;
	localparam int POS_W   = 4;
	localparam int SIZE_W  = 5;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	// internal coordinate / dimension width (holds up to 127 and coord + size)
	localparam int CW = 7;
	// internal linear cell index width
	localparam int IW = 12;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PROBE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PLACE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_FREE  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_MOVE  = 3'd4;

	// access into the occupancy map
	typedef struct packed {
		logic          we;
		logic          wdata;
		logic [IW-1:0] addr;
	} occ_req_t;

	// status back from the occupancy map
	typedef struct packed {
		logic busy;
		logic rd;
	} occ_st_t;

endpackage

FILE: design/groa_if.sv
// ----------------------------------------------------------------------------
// groa_req_if / groa_rsp_if
// valid/ready channels carrying allocator requests and responses
// ----------------------------------------------------------------------------
interface groa_req_if import groa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  anchor_x;
	logic [POS_W-1:0]  anchor_y;
	logic [POS_W-1:0]  old_x;
	logic [POS_W-1:0]  old_y;
	logic [SIZE_W-1:0] rect_width;
	logic [SIZE_W-1:0] rect_height;

	modport source (
		output valid, func, anchor_x, anchor_y, old_x, old_y, rect_width, rect_height,
		input  ready
	);
	modport sink (
		input  valid, func, anchor_x, anchor_y, old_x, old_y, rect_width, rect_height,
		output ready
	);
endinterface

interface groa_rsp_if import groa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             ok;
	logic [POS_W-1:0] slot_x;
	logic [POS_W-1:0] slot_y;

	modport source (
		output valid, ok, slot_x, slot_y,
		input  ready
	);
	modport sink (
		input  valid, ok, slot_x, slot_y,
		output ready
	);
endinterface

FILE: design/groa_occ_map.sv
// ----------------------------------------------------------------------------
// groa_occ_map
// one-bit-per-cell occupancy memory with a clearing sweep after reset
// ----------------------------------------------------------------------------
module groa_occ_map import groa_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  occ_req_t req,
	output occ_st_t  st
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic          mem [DEPTH];
	logic [AW-1:0] clr_idx_q;
	logic          busy_q;
	logic          rd_q;

	// clearing sweep, one cell a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == LAST) begin
				busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= 1'b0;
		end else if (req.we) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		rd_q <= mem[req.addr[AW-1:0]];
	end

	assign st.busy = busy_q;
	assign st.rd   = rd_q;

endmodule

FILE: design/grid_rect_occupancy_allocator.sv
// ----------------------------------------------------------------------------
// grid_rect_occupancy_allocator
// first-fit rectangle allocator over a one-bit-per-cell occupancy grid
// ----------------------------------------------------------------------------
// One request word in, one response word out. The grid lives in a single-port
// memory of MAX_COLS*MAX_ROWS bits addressed by row*width+col, and every
// operation is done by one shared cell walker that steps through a rectangle
// a cell at a time: a fit check addresses each cell and then tests the
// registered read, a mark or clear writes each cell as it passes, and each
// walk starts with a setup step for the row base multiply. A request also
// passes through a decode step before its walks and a response load step
// after them. Allocate tries anchors in row-major order and stops at the first
// occupied cell of each attempt, moving on to the next anchor. The block takes
// no new request while one is at work, but the next request may be taken
// while the previous response still waits. After reset the memory is cleared
// one cell a cycle, and no request is taken during that sweep; configuration
// writes are taken as ever.
// ----------------------------------------------------------------------------
module grid_rect_occupancy_allocator import groa_pkg::*; #(
	parameter int MAX_COLS = 16,
	parameter int MAX_ROWS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	groa_req_if.sink             req,
	groa_rsp_if.source           rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_ANCHOR,
		S_BASE,
		S_CELL,
		S_EVAL,
		S_FINISH
	} state_t;

	// what the current walk does to the cells it visits
	typedef enum logic [1:0] {
		PASS_CHECK,
		PASS_MARK,
		PASS_CLEAR,
		PASS_MOVE_CLR
	} pass_t;

	// grid size registers
	logic [CFG_DAT_W-1:0] grid_w_q, grid_h_q;
	logic [CW-1:0]        w_eff, h_eff;

	// latched request
	logic [FUNC_W-1:0] func_q;
	logic [POS_W-1:0]  ax_q, ay_q, ox_q, oy_q;
	logic [SIZE_W-1:0] rw_q, rh_q;

	// walker
	state_t            state_q;
	pass_t             pass_q;
	logic [CW-1:0]     bx_q, by_q;
	logic [SIZE_W-1:0] dx_q, dy_q;
	logic [IW-1:0]     row_base_q;
	logic [IW-1:0]     cells_q;
	logic [CW-1:0]     cand_x_q, cand_y_q;

	// result
	logic             res_ok_q;
	logic [POS_W-1:0] res_x_q, res_y_q;
	logic             rsp_valid_q;
	logic             rsp_ok_q;
	logic [POS_W-1:0] rsp_x_q, rsp_y_q;

	logic [CW-1:0]   cur_x, cur_y;
	logic [IW-1:0]   idx;
	logic            in_old;
	logic            last_col, last_cell;
	logic            step;
	logic            size_ok, anchor_ok;
	logic [CW-1:0]   mul_a;
	logic [2*CW-1:0] mul_p;
	logic            accept;

	occ_req_t occ_req;
	occ_st_t  occ_st;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= CFG_DAT_W'(16);
			grid_h_q <= CFG_DAT_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  grid_w_q <= cfg_data;
				CFG_GRID_HEIGHT: grid_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// grid size in use, clamped to the memory shape
	assign w_eff = (CW'(grid_w_q) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(grid_w_q);
	assign h_eff = (CW'(grid_h_q) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(grid_h_q);

	// ------------------------------------------------------------------
	// shared arithmetic
	// ------------------------------------------------------------------
	// one multiplier: grid cell count in decode, row base at walk start
	assign mul_a = (state_q == S_PREP) ? h_eff : by_q;
	assign mul_p = mul_a * w_eff;

	assign cur_x = bx_q + CW'(dx_q);
	assign cur_y = by_q + CW'(dy_q);
	assign idx   = row_base_q + IW'(cur_x);

	// cell belongs to the item's own old rectangle (move only)
	assign in_old = (func_q == FN_MOVE)
		&& (cur_x >= CW'(ox_q)) && (cur_x < CW'(ox_q) + CW'(rw_q))
		&& (cur_y >= CW'(oy_q)) && (cur_y < CW'(oy_q) + CW'(rh_q));

	assign last_col  = (dx_q == rw_q - 1'b1);
	assign last_cell = last_col && (dy_q == rh_q - 1'b1);

	// walker moves on: write cells, skipped cells, or a check that read free
	assign step = ((state_q == S_CELL) && ((pass_q != PASS_CHECK) || in_old))
		|| ((state_q == S_EVAL) && !occ_st.rd);

	assign size_ok = (rw_q != '0) && (rh_q != '0)
		&& (CW'(rw_q) <= w_eff) && (CW'(rh_q) <= h_eff);
	assign anchor_ok = (rw_q != '0) && (rh_q != '0)
		&& (CW'(ax_q) + CW'(rw_q) <= w_eff) && (CW'(ay_q) + CW'(rh_q) <= h_eff);

	// linear indexes past the grid are skipped on writes
	assign occ_req.we    = (state_q == S_CELL) && (pass_q != PASS_CHECK) && (idx < cells_q);
	assign occ_req.wdata = (pass_q == PASS_MARK);
	assign occ_req.addr  = idx;

	groa_occ_map #(
		.DEPTH (MAX_COLS * MAX_ROWS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (occ_req),
		.st     (occ_st)
	);

	assign req.ready = (state_q == S_IDLE) && !occ_st.busy;
	assign accept    = req.valid && req.ready;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= PASS_CHECK;
			func_q      <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			rw_q        <= '0;
			rh_q        <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			row_base_q  <= '0;
			cells_q     <= '0;
			cand_x_q    <= '0;
			cand_y_q    <= '0;
			res_ok_q    <= 1'b0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_ok_q    <= 1'b0;
			rsp_x_q     <= '0;
			rsp_y_q     <= '0;
		end else begin
			// in S_FINISH the load below handles the response register
			if (rsp_valid_q && rsp.ready && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end

			if (step) begin
				if (!last_cell) begin
					// next cell of the rectangle
					if (last_col) begin
						dx_q       <= '0;
						dy_q       <= dy_q + 1'b1;
						row_base_q <= row_base_q + IW'(w_eff);
					end else begin
						dx_q <= dx_q + 1'b1;
					end
					state_q <= S_CELL;
				end else begin
					// walk finished
					case (pass_q)
						PASS_CHECK: begin
							case (func_q)
								FN_ALLOC: begin
									res_x_q <= cand_x_q[POS_W-1:0];
									res_y_q <= cand_y_q[POS_W-1:0];
									pass_q  <= PASS_MARK;
									state_q <= S_BASE;
								end
								FN_PLACE: begin
									pass_q  <= PASS_MARK;
									state_q <= S_BASE;
								end
								FN_MOVE: begin
									bx_q    <= CW'(ox_q);
									by_q    <= CW'(oy_q);
									pass_q  <= PASS_MOVE_CLR;
									state_q <= S_BASE;
								end
								FN_PROBE: begin
									res_ok_q <= 1'b1;
									state_q  <= S_FINISH;
								end
								default: begin
									res_ok_q <= 1'b0;
									state_q  <= S_FINISH;
								end
							endcase
						end
						PASS_MOVE_CLR: begin
							bx_q    <= CW'(ax_q);
							by_q    <= CW'(ay_q);
							pass_q  <= PASS_MARK;
							state_q <= S_BASE;
						end
						default: begin
							res_ok_q <= 1'b1;
							state_q  <= S_FINISH;
						end
					endcase
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (accept) begin
							func_q  <= req.func;
							ax_q    <= req.anchor_x;
							ay_q    <= req.anchor_y;
							ox_q    <= req.old_x;
							oy_q    <= req.old_y;
							rw_q    <= req.rect_width;
							rh_q    <= req.rect_height;
							state_q <= S_PREP;
						end
					end
					S_PREP: begin
						cells_q  <= IW'(mul_p);
						res_ok_q <= 1'b0;
						// allocate reports the found spot, all else echo the anchor
						res_x_q  <= (func_q == FN_ALLOC) ? '0 : ax_q;
						res_y_q  <= (func_q == FN_ALLOC) ? '0 : ay_q;
						bx_q     <= CW'(ax_q);
						by_q     <= CW'(ay_q);
						case (func_q)
							FN_ALLOC: begin
								cand_x_q <= '0;
								cand_y_q <= '0;
								state_q  <= size_ok ? S_ANCHOR : S_FINISH;
							end
							FN_PROBE, FN_PLACE, FN_MOVE: begin
								pass_q  <= PASS_CHECK;
								state_q <= anchor_ok ? S_BASE : S_FINISH;
							end
							FN_FREE: begin
								pass_q  <= PASS_CLEAR;
								state_q <= size_ok ? S_BASE : S_FINISH;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
					S_ANCHOR: begin
						// row-major scan of candidate anchors
						if (cand_y_q + CW'(rh_q) > h_eff) begin
							state_q <= S_FINISH;
						end else if (cand_x_q + CW'(rw_q) > w_eff) begin
							cand_x_q <= '0;
							cand_y_q <= cand_y_q + 1'b1;
						end else begin
							bx_q    <= cand_x_q;
							by_q    <= cand_y_q;
							pass_q  <= PASS_CHECK;
							state_q <= S_BASE;
						end
					end
					S_BASE: begin
						row_base_q <= IW'(mul_p);
						dx_q       <= '0;
						dy_q       <= '0;
						state_q    <= S_CELL;
					end
					S_CELL: begin
						// only a check of a cell outside the old rectangle lands here
						state_q <= S_EVAL;
					end
					S_EVAL: begin
						// occupied cell hit
						if (func_q == FN_ALLOC) begin
							cand_x_q <= cand_x_q + 1'b1;
							state_q  <= S_ANCHOR;
						end else begin
							res_ok_q <= 1'b0;
							state_q  <= S_FINISH;
						end
					end
					S_FINISH: begin
						if (!rsp_valid_q || rsp.ready) begin
							rsp_valid_q <= 1'b1;
							rsp_ok_q    <= res_ok_q;
							rsp_x_q     <= res_x_q;
							rsp_y_q     <= res_y_q;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.ok     = rsp_ok_q;
	assign rsp.slot_x = rsp_x_q;
	assign rsp.slot_y = rsp_y_q;

`ifndef SYNTHESIS
	// map is never written while waiting for a request
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !occ_req.we)
		else $error("occupancy written while idle");

	// no request taken during the clearing sweep
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		occ_st.busy |-> !req.ready)
		else $error("request taken while map clears");

	// walker offsets stay inside the rectangle
	a_walk_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CELL || state_q == S_EVAL) |-> (dx_q < rw_q && dy_q < rh_q))
		else $error("walker left the rectangle");

	// a finished result waits while the previous response is stalled
	a_hold_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && rsp.valid && !rsp.ready) |=> state_q == S_FINISH)
		else $error("pending response overwritten");

	// an accepted request always goes to decode
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q == S_PREP)
		else $error("accepted request not decoded");
`endif

endmodule
